// File: hw/rtl/rif_pkg.sv
package rif_pkg;

  localparam int MAX_TAPS      = 64;
  localparam int TAP_AW        = $clog2(MAX_TAPS);
  localparam int TAP_CW        = TAP_AW + 1;
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_UPSAMPLE  = 16;
  localparam int SPS_W         = 5;
  localparam int PROD_W        = 2 * SAMPLE_BITS;
  localparam int ACC_W         = PROD_W + TAP_AW;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;

  localparam logic [SPS_W-1:0]  SPS_RESET  = SPS_W'(4);
  localparam logic [TAP_CW-1:0] TAPS_RESET = TAP_CW'(33);

  typedef enum logic [1:0] {
    CMD_LOAD_TAP = 2'd0,
    CMD_PUSH     = 2'd1,
    CMD_FLUSH    = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPSAMPLE = 1'b0,
    REG_TAPS     = 1'b1
  } reg_idx_t;

endpackage

// File: hw/rtl/rrc_interpolating_fir.sv
// Complex interpolating FIR for RRC pulse shaping (upsample_factor 1 gives the
// matched filter). Real Q1.15 taps are loaded one per load-tap beat into a
// 64-entry tap RAM; complex samples live in a 64-entry circular history RAM.
// A push beat emits upsample_factor results (clamped to 1..16), a flush
// beat emits active_taps-1 tail results (active_taps clamped to 1..64) and
// then clears the history; run_last marks the final result of each beat.
// Each result is built by the single tap/history read port pair feeding one
// complex MAC per cycle over the active taps. Load-tap beats leave the filter
// idle, so input does not stall after them. Input stalls while an item is in
// progress; a finished result waits in the output register without holding
// up the filter, unless the next one is ready before it is taken.
module rrc_interpolating_fir (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [rif_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rif_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [rif_pkg::TAP_AW-1:0]          tap_index,
  input  logic signed [rif_pkg::SAMPLE_BITS-1:0] tap_value,
  input  logic signed [rif_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [rif_pkg::SAMPLE_BITS-1:0] sample_q,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rif_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [rif_pkg::SAMPLE_BITS-1:0] out_q,
  output logic                                run_last
);

  localparam int SB = rif_pkg::SAMPLE_BITS;
  localparam int AW = rif_pkg::TAP_AW;
  localparam int CW = rif_pkg::TAP_CW;
  localparam int AC = rif_pkg::ACC_W;
  localparam int PW = rif_pkg::PROD_W;
  localparam int SHW = AC - (SB - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_MAC  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [rif_pkg::SPS_W-1:0] upsample_factor;
  logic [CW-1:0]             active_taps;

  // Memories
  logic signed [SB-1:0]   tap_mem [rif_pkg::MAX_TAPS];
  logic [2*SB-1:0]        hist_mem [rif_pkg::MAX_TAPS];
  logic [rif_pkg::MAX_TAPS-1:0] tap_vld;
  logic [rif_pkg::MAX_TAPS-1:0] hist_vld;

  logic [AW-1:0]        head;
  logic [CW-1:0]        k;
  logic [CW-1:0]        n_taps;
  logic [AW-1:0]        remaining;
  logic                 is_flush;
  logic signed [SB-1:0] cur_i;
  logic signed [SB-1:0] cur_q;

  logic                 rd_v;
  logic signed [SB-1:0] tap_rd;
  logic                 tap_rd_ok;
  logic [2*SB-1:0]      hist_rd;
  logic                 hist_rd_ok;

  logic                 pr_v;
  logic signed [PW-1:0] prod_i;
  logic signed [PW-1:0] prod_q;
  logic signed [AC-1:0] acc_i;
  logic signed [AC-1:0] acc_q;

  logic [rif_pkg::SPS_W-1:0] sps_eff;
  logic [CW-1:0]             n_eff;
  logic                      accept;
  logic                      issue;
  logic                      out_free;
  logic [AW-1:0]             head_inc;
  logic [AW-1:0]             rd_addr;
  logic signed [SB-1:0]      tap_use;
  logic signed [SB-1:0]      hist_i_use;
  logic signed [SB-1:0]      hist_q_use;
  logic signed [SB-1:0]      res_i;
  logic signed [SB-1:0]      res_q;

  function automatic logic signed [SB-1:0] round_sat(input logic signed [AC-1:0] a);
    logic signed [AC-1:0]  v;
    logic signed [SHW-1:0] r;
    logic signed [SHW-1:0] maxv;
    logic signed [SHW-1:0] minv;
    v    = a + AC'(1 << (SB - 2));
    r    = SHW'(v >>> (SB - 1));
    maxv = SHW'((1 << (SB - 1)) - 1);
    minv = -maxv - SHW'(1);
    if (r > maxv) begin
      round_sat = maxv[SB-1:0];
    end else if (r < minv) begin
      round_sat = minv[SB-1:0];
    end else begin
      round_sat = r[SB-1:0];
    end
  endfunction

  always_comb begin
    sps_eff = upsample_factor;
    if (upsample_factor == '0) sps_eff = rif_pkg::SPS_W'(1);
    if (upsample_factor > rif_pkg::SPS_W'(rif_pkg::MAX_UPSAMPLE)) begin
      sps_eff = rif_pkg::SPS_W'(rif_pkg::MAX_UPSAMPLE);
    end
    n_eff = active_taps;
    if (active_taps == '0) n_eff = CW'(1);
    if (active_taps > CW'(rif_pkg::MAX_TAPS)) n_eff = CW'(rif_pkg::MAX_TAPS);
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign issue    = (state == S_MAC) && (k != n_taps);
  assign out_free = !out_valid || !out_stall;
  assign head_inc = head + AW'(1);
  assign rd_addr  = head - k[AW-1:0];

  assign tap_use    = tap_rd_ok  ? tap_rd : '0;
  assign hist_i_use = hist_rd_ok ? hist_rd[2*SB-1:SB] : '0;
  assign hist_q_use = hist_rd_ok ? hist_rd[SB-1:0] : '0;
  assign res_i      = round_sat(acc_i);
  assign res_q      = round_sat(acc_q);

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      upsample_factor <= rif_pkg::SPS_RESET;
      active_taps     <= rif_pkg::TAPS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        rif_pkg::REG_UPSAMPLE: upsample_factor <= cfg_data[rif_pkg::SPS_W-1:0];
        rif_pkg::REG_TAPS:     active_taps     <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Tap RAM
  always_ff @(posedge clk) begin
    if (accept && cmd == rif_pkg::CMD_LOAD_TAP) begin
      tap_mem[tap_index] <= tap_value;
    end
    tap_rd <= tap_mem[k[AW-1:0]];
  end

  // History RAM
  always_ff @(posedge clk) begin
    if (state == S_PUSH) begin
      hist_mem[head_inc] <= {cur_i, cur_q};
    end
    hist_rd <= hist_mem[rd_addr];
  end

  // Datapath pipeline: read -> product -> accumulate
  always_ff @(posedge clk) begin
    tap_rd_ok  <= tap_vld[k[AW-1:0]];
    hist_rd_ok <= hist_vld[rd_addr];
    prod_i     <= tap_use * hist_i_use;
    prod_q     <= tap_use * hist_q_use;
    if (state == S_PUSH) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (pr_v) begin
      acc_i <= acc_i + AC'(prod_i);
      acc_q <= acc_q + AC'(prod_q);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_vld   <= '0;
      hist_vld  <= '0;
      head      <= '0;
      k         <= '0;
      rd_v      <= 1'b0;
      pr_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v <= issue;
      pr_v <= rd_v;
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            n_taps <= n_eff;
            case (cmd)
              rif_pkg::CMD_LOAD_TAP: tap_vld[tap_index] <= 1'b1;
              rif_pkg::CMD_PUSH: begin
                cur_i     <= sample_i;
                cur_q     <= sample_q;
                remaining <= AW'(sps_eff);
                is_flush  <= 1'b0;
                state     <= S_PUSH;
              end
              rif_pkg::CMD_FLUSH: begin
                cur_i     <= '0;
                cur_q     <= '0;
                is_flush  <= 1'b1;
                if (n_eff == CW'(1)) begin
                  hist_vld <= '0;
                  head     <= '0;
                end else begin
                  remaining <= AW'(n_eff - CW'(1));
                  state     <= S_PUSH;
                end
              end
              default: ;
            endcase
          end
        end
        S_PUSH: begin
          head               <= head_inc;
          hist_vld[head_inc] <= 1'b1;
          k                  <= '0;
          state              <= S_MAC;
        end
        S_MAC: begin
          if (issue) begin
            k <= k + CW'(1);
          end else if (!rd_v && !pr_v) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_i     <= res_i;
            out_q     <= res_q;
            run_last  <= (remaining == AW'(1));
            // Later phases of a push are stuffed zeros
            cur_i     <= '0;
            cur_q     <= '0;
            remaining <= remaining - AW'(1);
            if (remaining == AW'(1)) begin
              if (is_flush) begin
                hist_vld <= '0;
                head     <= '0;
              end
              state <= S_IDLE;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/rif_checker.sv
module rif_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [1:0]                     cmd,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [rif_pkg::SAMPLE_BITS-1:0] out_i,
  input logic [rif_pkg::SAMPLE_BITS-1:0] out_q,
  input logic                           run_last
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q)
                               && $stable(run_last))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("outputs active after reset");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && cmd == rif_pkg::CMD_PUSH |=> in_stall)
    else $error("push beat did not occupy the filter");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_beat && (cmd == rif_pkg::CMD_LOAD_TAP || cmd == rif_pkg::CMD_UNUSED) |=> !in_stall)
    else $error("load or unused beat stalled input");

  a_push_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_beat && cmd == rif_pkg::CMD_PUSH && !out_valid |=> !out_valid)
    else $error("result appeared before filtering");

endmodule

bind rrc_interpolating_fir rif_checker u_rif_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_i     (out_i),
  .out_q     (out_q),
  .run_last  (run_last)
);
